// ----- sv/lifo_stack_allocator_top_defines.svh -----
// assertion macros shared by the allocator rtl
`ifndef LIFO_STACK_ALLOCATOR_TOP_DEFINES_SVH
`define LIFO_STACK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define LSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define LSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lsa_pkg.sv -----
`default_nettype none
package lsa_pkg;

  localparam int MAX_RECORDS = 64;
  // alignment must be a power of two: rounding is an add and a mask
  localparam int ALIGN_BYTES = 4096;

  localparam int BYTES_W     = 40;
  localparam int OFFSET_W    = 41;
  localparam int BASE_W      = 47;
  localparam int ADDR_W      = 48;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = $clog2(MAX_RECORDS + 1);
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 47;

  localparam logic [OFFSET_W-1:0] ALIGN_MASK = OFFSET_W'(ALIGN_BYTES - 1);
  localparam logic [COUNT_W-1:0]  COUNT_FULL = COUNT_W'(MAX_RECORDS);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_MEMORY   = 3'd1,
    ST_STACK_FULL  = 3'd2,
    ST_FREE_EMPTY  = 3'd3,
    ST_FREE_WRONG  = 3'd4
  } lsa_status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } lsa_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_ADDRESS = 1'b0,
    REG_CAPACITY     = 1'b1
  } lsa_reg_t;

  // shift command for the record chain
  typedef struct packed {
    logic push;
    logic pop;
  } lsa_shift_t;

endpackage
`default_nettype wire

// ----- sv/lsa_if.sv -----
`default_nettype none
interface lsa_req_if import lsa_pkg::*; ();
  logic                kind;
  logic [BYTES_W-1:0]  request_bytes;
  logic [ADDR_W-1:0]   free_address;
  logic                valid;
  logic                ready;

  modport source (output valid, kind, request_bytes, free_address, input ready);
  modport sink   (input valid, kind, request_bytes, free_address, output ready);
endinterface

interface lsa_rsp_if import lsa_pkg::*; ();
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_address;
  logic [OFFSET_W-1:0] used_bytes;
  logic [OFFSET_W-1:0] peak_bytes;
  logic                valid;
  logic                ready;

  modport source (output valid, status, granted_address, used_bytes, peak_bytes,
                  input ready);
  modport sink   (input valid, status, granted_address, used_bytes, peak_bytes,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/lsa_cell.sv -----
`default_nettype none
module lsa_cell import lsa_pkg::*; (
  input  wire logic                clk,
  input  wire lsa_shift_t          shift,
  input  wire logic [OFFSET_W-1:0] from_newer,
  input  wire logic [OFFSET_W-1:0] from_older,
  output logic      [OFFSET_W-1:0] value
);

  // push moves records one place deeper, pop one place up
  always_ff @(posedge clk) begin
    if (shift.push) begin
      value <= from_newer;
    end else if (shift.pop) begin
      value <= from_older;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lsa_stack.sv -----
`default_nettype none
module lsa_stack import lsa_pkg::*; (
  input  wire logic                clk,
  input  wire lsa_shift_t          shift,
  input  wire logic [OFFSET_W-1:0] push_data,
  output logic      [OFFSET_W-1:0] top_data
);

  logic [OFFSET_W-1:0] cell_value [MAX_RECORDS];

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic [OFFSET_W-1:0] newer;
    logic [OFFSET_W-1:0] older;

    if (i == 0) begin : g_head
      assign newer = push_data;
    end else begin : g_body
      assign newer = cell_value[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign older = cell_value[i];
    end else begin : g_inner
      assign older = cell_value[i+1];
    end

    lsa_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_newer (newer),
      .from_older (older),
      .value      (cell_value[i])
    );
  end

  assign top_data = cell_value[0];

endmodule
`default_nettype wire

// ----- sv/lifo_stack_allocator_top.sv -----
// channel   dir  payload                                          handshake
// req       in   kind, request_bytes, free_address                valid/ready
// rsp       out  status, granted_address, used_bytes, peak_bytes  valid/ready
// cfg       in   cfg_index, cfg_data                              cfg_we, no wait
//
// one request per cycle while rsp is empty or being taken: decision, push/pop and result register in one step
// records sit in a chain of cells, newest in the head cell, shifted on push/pop
// rst (synchronous) clears offsets, count, peak, config registers and rsp valid
// cell contents are not reset: only entries below the count are ever read
// a new request is taken while rsp is empty or being taken in the same cycle
`default_nettype none
`include "lifo_stack_allocator_top_defines.svh"
module lifo_stack_allocator_top import lsa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  lsa_req_if.sink                     req,
  lsa_rsp_if.source                   rsp
);

  // configuration registers
  logic [BASE_W-1:0]   base_address;
  logic [OFFSET_W-1:0] capacity;

  // allocator state
  logic [OFFSET_W-1:0] top_offset;
  logic [OFFSET_W-1:0] top_offset_next;
  logic [COUNT_W-1:0]  record_count;
  logic [COUNT_W-1:0]  record_count_next;
  logic [OFFSET_W-1:0] peak_used;
  logic [OFFSET_W-1:0] peak_used_next;

  // result register
  logic                out_valid;
  lsa_status_t         out_status;
  lsa_status_t         out_status_next;
  logic [ADDR_W-1:0]   out_granted;
  logic [ADDR_W-1:0]   out_granted_next;

  // datapath
  logic                req_fire;
  lsa_shift_t          shift;
  lsa_shift_t          shift_cmd;
  logic [OFFSET_W-1:0] newest_start;
  logic [OFFSET_W-1:0] amount;
  logic [OFFSET_W:0]   new_top;
  logic                no_memory;
  logic [ADDR_W-1:0]   grant_addr;
  logic [ADDR_W-1:0]   newest_addr;

  assign req.ready = !out_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      capacity     <= '0;
    end else if (cfg_we) begin
      case (lsa_reg_t'(cfg_index))
        REG_BASE_ADDRESS: base_address <= cfg_data[BASE_W-1:0];
        REG_CAPACITY:     capacity     <= cfg_data[OFFSET_W-1:0];
        default:          ;
      endcase
    end
  end

  // ---- arithmetic ----
  // round up to the alignment: add mask, then clear the low bits
  assign amount = (OFFSET_W'(req.request_bytes) + ALIGN_MASK) & ~ALIGN_MASK;
  assign new_top   = {1'b0, top_offset} + {1'b0, amount};
  assign no_memory = new_top > {1'b0, capacity};
  // addresses wrap at 48 bits
  assign grant_addr  = ADDR_W'(base_address) + ADDR_W'(top_offset);
  assign newest_addr = ADDR_W'(base_address) + ADDR_W'(newest_start);

  // ---- decision ----
  always_comb begin
    top_offset_next   = top_offset;
    record_count_next = record_count;
    peak_used_next    = peak_used;
    out_status_next   = ST_OK;
    out_granted_next  = '0;
    shift_cmd         = '0;

    case (lsa_kind_t'(req.kind))
      KIND_ALLOC: begin
        if (no_memory) begin
          out_status_next = ST_NO_MEMORY;
        end else if (record_count >= COUNT_FULL) begin
          out_status_next = ST_STACK_FULL;
        end else begin
          shift_cmd.push    = 1'b1;
          out_granted_next  = grant_addr;
          top_offset_next   = new_top[OFFSET_W-1:0];
          record_count_next = record_count + COUNT_W'(1);
          if (new_top[OFFSET_W-1:0] > peak_used) begin
            peak_used_next = new_top[OFFSET_W-1:0];
          end
        end
      end
      KIND_FREE: begin
        if (record_count == '0) begin
          out_status_next = ST_FREE_EMPTY;
        end else if (newest_addr != req.free_address) begin
          out_status_next = ST_FREE_WRONG;
        end else begin
          shift_cmd.pop     = 1'b1;
          top_offset_next   = newest_start;
          record_count_next = record_count - COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // chain only moves on an accepted request
  always_comb begin
    shift.push = req_fire && shift_cmd.push;
    shift.pop  = req_fire && shift_cmd.pop;
  end

  // ---- state and result registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      top_offset   <= '0;
      record_count <= '0;
      peak_used    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (req_fire) begin
        top_offset   <= top_offset_next;
        record_count <= record_count_next;
        peak_used    <= peak_used_next;
        out_valid    <= 1'b1;
      end else if (rsp.ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      out_status  <= out_status_next;
      out_granted <= out_granted_next;
    end
  end

  // ---- record chain ----
  lsa_stack u_stack (
    .clk       (clk),
    .shift     (shift),
    .push_data (top_offset),
    .top_data  (newest_start)
  );

  // ---- result port ----
  // used and peak are the registered state, which only moves with a new result
  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.granted_address = out_granted;
  assign rsp.used_bytes      = top_offset;
  assign rsp.peak_bytes      = peak_used;

  // ---- checks ----
  `LSA_ASSERT_NOW(a_count_bound, 1'b1, record_count <= COUNT_FULL, "record count past depth")
  `LSA_ASSERT_NOW(a_top_below_peak, 1'b1, top_offset <= peak_used, "top offset above peak")
  `LSA_ASSERT_NEXT(a_push_counts, req_fire && shift_cmd.push, record_count == $past(record_count) + COUNT_W'(1), "push did not bump count")
  `LSA_ASSERT_NEXT(a_pop_restores, req_fire && shift_cmd.pop, top_offset == $past(newest_start), "pop did not restore top")

endmodule
`default_nettype wire
